// ===== hw/rtl/rcdsa_pkg.sv =====
// Shared types and constants for the reference-counted descriptor slot allocator.
`timescale 1ns / 1ps
`default_nettype none

package rcdsa_pkg;

  localparam int GLOBAL_SLOTS_DEF = 1024;
  localparam int LOCAL_SLOTS_DEF  = 256;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int OP_W        = 3;
  localparam int SLOT_IN_W   = 10;
  localparam int FD_W        = 8;
  localparam int STATUS_W    = 2;
  localparam int VALUE_W     = 10;
  localparam int WORD_W      = 32;
  localparam int WORD_IDX_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_ADD_REF = 3'd1,
    OP_RELEASE = 3'd2,
    OP_CLOSE   = 3'd3,
    OP_DUP     = 3'd4,
    OP_DUP3    = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_BAD   = 2'd2,
    STS_COUNT = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_BM_RD,
    S_BM_CHK,
    S_LV_SCAN,
    S_LM_RD,
    S_LM_GOT,
    S_LM_RD2,
    S_LM_GOT2,
    S_T_RD,
    S_T_CHK,
    S_CNT_RD,
    S_CNT_CHK,
    S_T_WR,
    S_FB_RD,
    S_FB_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic                  found;
    logic [WORD_IDX_W-1:0] idx;
  } ffz_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rcdsa_ram.sv =====
// Simple dual-port memory with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rcdsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rcdsa_ffz.sv =====
// Find-first-zero unit that returns the lowest clear bit of one word.
`timescale 1ns / 1ps
`default_nettype none

module rcdsa_ffz (
  input  wire logic [rcdsa_pkg::WORD_W-1:0] word_i,
  output rcdsa_pkg::ffz_res_t               res_o
);

  always_comb begin
    res_o = '0;
    for (int b = rcdsa_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!word_i[b]) begin
        res_o.found = 1'b1;
        res_o.idx   = rcdsa_pkg::WORD_IDX_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/refcounted_descriptor_slot_allocator.sv =====
// Add_ref and release do a read-modify-write of the count memory; close and dup first read
// the local map, alloc and dup search the bitmap and the local valid words word by word
// through the shared find-first-zero unit, and dup3 reads two local map entries.
// One transaction is in work at a time; the next is accepted once the result is registered.
// After reset a clearing pass zeroes the counts and bitmap, input stalled.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_descriptor_slot_allocator #(
  parameter int GLOBAL_SLOTS = rcdsa_pkg::GLOBAL_SLOTS_DEF,
  parameter int LOCAL_SLOTS  = rcdsa_pkg::LOCAL_SLOTS_DEF,
  parameter int COUNT_BITS   = rcdsa_pkg::COUNT_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [rcdsa_pkg::OP_W-1:0]         operation_i,
  input  wire logic [rcdsa_pkg::SLOT_IN_W-1:0]    slot_i,
  input  wire logic [rcdsa_pkg::FD_W-1:0]         local_fd_i,
  input  wire logic [rcdsa_pkg::FD_W-1:0]         target_fd_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [rcdsa_pkg::STATUS_W-1:0]     status_o,
  output logic      [rcdsa_pkg::VALUE_W-1:0]      value_o,
  output logic                                    slot_freed_o
);

  localparam int WORD_W = rcdsa_pkg::WORD_W;
  localparam int WIW    = rcdsa_pkg::WORD_IDX_W;
  localparam int SW     = $clog2(GLOBAL_SLOTS);
  localparam int GW     = (GLOBAL_SLOTS + WORD_W - 1) / WORD_W;
  localparam int GWA    = (GW > 1) ? $clog2(GW) : 1;
  localparam int LIW    = $clog2(LOCAL_SLOTS);
  localparam int LW     = (LOCAL_SLOTS + WORD_W - 1) / WORD_W;
  localparam int LWA    = (LW > 1) ? $clog2(LW) : 1;
  localparam int WW     = (GWA > LWA) ? GWA : LWA;

  rcdsa_pkg::state_e state_q, state_d;

  logic [rcdsa_pkg::OP_W-1:0]      op_q;
  logic [rcdsa_pkg::SLOT_IN_W-1:0] slot_q;
  logic [rcdsa_pkg::FD_W-1:0]      fd_q, tfd_q;

  logic [SW-1:0]         ks_q, ks_d, ts_q, ts_d, clr_q, clr_d;
  logic [LIW-1:0]        nf_q, nf_d;
  logic [WW-1:0]         w_q, w_d;
  logic [COUNT_BITS-1:0] tcnt_q, tcnt_d;

  rcdsa_pkg::status_e               res_status_q, res_status_d;
  logic [rcdsa_pkg::VALUE_W-1:0]    res_value_q, res_value_d;
  logic                             res_freed_q, res_freed_d;

  logic                             out_valid_q, out_valid_d;
  rcdsa_pkg::status_e               out_status_q, out_status_d;
  logic [rcdsa_pkg::VALUE_W-1:0]    out_value_q, out_value_d;
  logic                             out_freed_q, out_freed_d;

  logic [LOCAL_SLOTS-1:0] lvalid_q;
  logic                   lv_set, lv_clr;
  logic [LIW-1:0]         lv_idx;

  logic                  cm_we;
  logic [SW-1:0]         cm_wa, cm_ra;
  logic [COUNT_BITS-1:0] cm_wd, cm_rd;
  logic                  bm_we;
  logic [GWA-1:0]        bm_wa, bm_ra;
  logic [WORD_W-1:0]     bm_wd, bm_rd;
  logic                  lm_we;
  logic [LIW-1:0]        lm_wa, lm_ra;
  logic [SW-1:0]         lm_wd, lm_rd;

  logic                  accept;
  logic                  out_free;
  logic                  g_bad, fd_bad, tfd_bad, sv, tv;
  logic [LIW-1:0]        fd_idx, tfd_idx;
  logic                  cnt_zero, cnt_one, cnt_max, tcnt_one;
  logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;
  logic [WORD_W-1:0]     bm_mask, bm_word_m, lv_word, ffz_in;
  logic [LW*WORD_W-1:0]  lv_pad;
  rcdsa_pkg::ffz_res_t   ffz_res;
  logic [GWA+WIW-1:0]    found_slot_full;
  logic [LWA+WIW-1:0]    found_fd_full;
  logic [SW-1:0]         found_slot, fslot;
  logic [LIW-1:0]        found_fd;
  logic                  w_g_last, w_l_last;
  logic [GWA-1:0]        fb_waddr;
  logic [WIW-1:0]        fb_bit;

  rcdsa_ram #(.WIDTH(COUNT_BITS), .DEPTH(GLOBAL_SLOTS), .AW(SW)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cm_we),
    .waddr_i (cm_wa),
    .wdata_i (cm_wd),
    .raddr_i (cm_ra),
    .rdata_o (cm_rd)
  );

  rcdsa_ram #(.WIDTH(WORD_W), .DEPTH(GW), .AW(GWA)) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_wa),
    .wdata_i (bm_wd),
    .raddr_i (bm_ra),
    .rdata_o (bm_rd)
  );

  rcdsa_ram #(.WIDTH(SW), .DEPTH(LOCAL_SLOTS), .AW(LIW)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (lm_we),
    .waddr_i (lm_wa),
    .wdata_i (lm_wd),
    .raddr_i (lm_ra),
    .rdata_o (lm_rd)
  );

  rcdsa_ffz u_ffz (
    .word_i (ffz_in),
    .res_o  (ffz_res)
  );

  assign accept   = (state_q == rcdsa_pkg::S_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  assign g_bad   = 32'(slot_q) >= GLOBAL_SLOTS;
  assign fd_bad  = 32'(fd_q) >= LOCAL_SLOTS;
  assign tfd_bad = 32'(tfd_q) >= LOCAL_SLOTS;
  assign fd_idx  = LIW'(fd_q);
  assign tfd_idx = LIW'(tfd_q);
  assign sv      = lvalid_q[fd_idx];
  assign tv      = lvalid_q[tfd_idx];

  assign cnt_zero = (cm_rd == '0);
  assign cnt_one  = (cm_rd == COUNT_BITS'(1));
  assign cnt_max  = &cm_rd;
  assign cnt_inc  = cm_rd + COUNT_BITS'(1);
  assign cnt_dec  = cm_rd - COUNT_BITS'(1);
  assign tcnt_one = (tcnt_q == COUNT_BITS'(1));

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      bm_mask[b] = ((32'(w_q[GWA-1:0]) << WIW) + 32'(b)) >= GLOBAL_SLOTS;
    end
  end

  always_comb begin
    lv_pad = '1;
    lv_pad[LOCAL_SLOTS-1:0] = lvalid_q;
  end

  assign bm_word_m = bm_rd | bm_mask;
  assign lv_word   = lv_pad[{w_q[LWA-1:0], WIW'(0)} +: WORD_W];
  assign ffz_in    = (state_q == rcdsa_pkg::S_BM_CHK) ? bm_word_m : lv_word;

  assign found_slot_full = {w_q[GWA-1:0], ffz_res.idx};
  assign found_slot      = found_slot_full[SW-1:0];
  assign found_fd_full   = {w_q[LWA-1:0], ffz_res.idx};
  assign found_fd        = found_fd_full[LIW-1:0];
  assign w_g_last        = (w_q[GWA-1:0] == GWA'(GW - 1));
  assign w_l_last        = (w_q[LWA-1:0] == LWA'(LW - 1));

  assign fslot    = (op_q == rcdsa_pkg::OP_DUP3) ? ts_q : ks_q;
  assign fb_waddr = GWA'(fslot >> WIW);
  assign fb_bit   = fslot[WIW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcdsa_pkg::S_CLEAR: begin
        if (clr_q == SW'(GLOBAL_SLOTS - 1)) begin
          state_d = rcdsa_pkg::S_IDLE;
        end
      end
      rcdsa_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = rcdsa_pkg::S_DECODE;
        end
      end
      rcdsa_pkg::S_DECODE: begin
        unique case (op_q)
          rcdsa_pkg::OP_ALLOC: state_d = rcdsa_pkg::S_BM_RD;
          rcdsa_pkg::OP_ADD_REF, rcdsa_pkg::OP_RELEASE: begin
            state_d = g_bad ? rcdsa_pkg::S_RESP : rcdsa_pkg::S_CNT_RD;
          end
          rcdsa_pkg::OP_CLOSE, rcdsa_pkg::OP_DUP: begin
            state_d = (fd_bad || !sv) ? rcdsa_pkg::S_RESP : rcdsa_pkg::S_LM_RD;
          end
          rcdsa_pkg::OP_DUP3: begin
            state_d = (fd_bad || tfd_bad) ? rcdsa_pkg::S_RESP : rcdsa_pkg::S_LM_RD;
          end
          default: state_d = rcdsa_pkg::S_RESP;
        endcase
      end
      rcdsa_pkg::S_BM_RD: state_d = rcdsa_pkg::S_BM_CHK;
      rcdsa_pkg::S_BM_CHK: begin
        state_d = (ffz_res.found || w_g_last) ? rcdsa_pkg::S_RESP : rcdsa_pkg::S_BM_RD;
      end
      rcdsa_pkg::S_LM_RD: state_d = rcdsa_pkg::S_LM_GOT;
      rcdsa_pkg::S_LM_GOT: begin
        priority if (op_q == rcdsa_pkg::OP_CLOSE) begin
          state_d = rcdsa_pkg::S_CNT_RD;
        end else if (op_q == rcdsa_pkg::OP_DUP) begin
          state_d = rcdsa_pkg::S_LV_SCAN;
        end else begin
          state_d = rcdsa_pkg::S_LM_RD2;
        end
      end
      rcdsa_pkg::S_LM_RD2: state_d = rcdsa_pkg::S_LM_GOT2;
      rcdsa_pkg::S_LM_GOT2: begin
        priority if (tv) begin
          state_d = rcdsa_pkg::S_T_RD;
        end else if (!sv) begin
          state_d = rcdsa_pkg::S_RESP;
        end else begin
          state_d = rcdsa_pkg::S_CNT_RD;
        end
      end
      rcdsa_pkg::S_T_RD: state_d = rcdsa_pkg::S_T_CHK;
      rcdsa_pkg::S_T_CHK: begin
        priority if (cnt_zero) begin
          state_d = rcdsa_pkg::S_RESP;
        end else if (!sv) begin
          state_d = cnt_one ? rcdsa_pkg::S_FB_RD : rcdsa_pkg::S_RESP;
        end else if (ts_q == ks_q) begin
          state_d = rcdsa_pkg::S_RESP;
        end else begin
          state_d = rcdsa_pkg::S_CNT_RD;
        end
      end
      rcdsa_pkg::S_LV_SCAN: begin
        priority if (ffz_res.found) begin
          state_d = rcdsa_pkg::S_CNT_RD;
        end else if (w_l_last) begin
          state_d = rcdsa_pkg::S_RESP;
        end else begin
          state_d = rcdsa_pkg::S_LV_SCAN;
        end
      end
      rcdsa_pkg::S_CNT_RD: state_d = rcdsa_pkg::S_CNT_CHK;
      rcdsa_pkg::S_CNT_CHK: begin
        unique case (op_q)
          rcdsa_pkg::OP_RELEASE, rcdsa_pkg::OP_CLOSE: begin
            state_d = (!cnt_zero && cnt_one) ? rcdsa_pkg::S_FB_RD : rcdsa_pkg::S_RESP;
          end
          rcdsa_pkg::OP_DUP3: begin
            state_d = (!cnt_zero && !cnt_max && tv) ? rcdsa_pkg::S_T_WR : rcdsa_pkg::S_RESP;
          end
          default: state_d = rcdsa_pkg::S_RESP;
        endcase
      end
      rcdsa_pkg::S_T_WR: state_d = tcnt_one ? rcdsa_pkg::S_FB_RD : rcdsa_pkg::S_RESP;
      rcdsa_pkg::S_FB_RD: state_d = rcdsa_pkg::S_FB_WR;
      rcdsa_pkg::S_FB_WR: state_d = rcdsa_pkg::S_RESP;
      rcdsa_pkg::S_RESP: begin
        if (out_free) begin
          state_d = rcdsa_pkg::S_IDLE;
        end
      end
      default: state_d = rcdsa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    clr_d        = clr_q;
    ks_d         = ks_q;
    ts_d         = ts_q;
    nf_d         = nf_q;
    w_d          = w_q;
    tcnt_d       = tcnt_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_freed_d  = res_freed_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_freed_d  = out_freed_q;
    lv_set       = 1'b0;
    lv_clr       = 1'b0;
    lv_idx       = tfd_idx;
    cm_we        = 1'b0;
    cm_wa        = ks_q;
    cm_wd        = cnt_inc;
    cm_ra        = ks_q;
    bm_we        = 1'b0;
    bm_wa        = w_q[GWA-1:0];
    bm_wd        = bm_rd | (WORD_W'(1) << ffz_res.idx);
    bm_ra        = w_q[GWA-1:0];
    lm_we        = 1'b0;
    lm_wa        = tfd_idx;
    lm_wd        = ks_q;
    lm_ra        = fd_idx;

    unique case (state_q)
      rcdsa_pkg::S_CLEAR: begin
        cm_we = 1'b1;
        cm_wa = clr_q;
        cm_wd = '0;
        bm_we = 32'(clr_q) < GW;
        bm_wa = GWA'(clr_q);
        bm_wd = '0;
        clr_d = clr_q + SW'(1);
      end
      rcdsa_pkg::S_DECODE: begin
        res_status_d = rcdsa_pkg::STS_OK;
        res_value_d  = '0;
        res_freed_d  = 1'b0;
        w_d          = '0;
        ks_d         = SW'(slot_q);
        unique case (op_q)
          rcdsa_pkg::OP_ADD_REF, rcdsa_pkg::OP_RELEASE: begin
            if (g_bad) begin
              res_status_d = rcdsa_pkg::STS_BAD;
            end
          end
          rcdsa_pkg::OP_CLOSE, rcdsa_pkg::OP_DUP: begin
            if (fd_bad || !sv) begin
              res_status_d = rcdsa_pkg::STS_BAD;
            end
          end
          rcdsa_pkg::OP_DUP3: begin
            if (fd_bad || tfd_bad) begin
              res_status_d = rcdsa_pkg::STS_BAD;
            end
          end
          default: ;
        endcase
      end
      rcdsa_pkg::S_BM_CHK: begin
        priority if (ffz_res.found) begin
          bm_we       = 1'b1;
          cm_we       = 1'b1;
          cm_wa       = found_slot;
          cm_wd       = COUNT_BITS'(1);
          res_value_d = rcdsa_pkg::VALUE_W'(found_slot);
        end else if (w_g_last) begin
          res_status_d = rcdsa_pkg::STS_FULL;
        end else begin
          w_d = w_q + WW'(1);
        end
      end
      rcdsa_pkg::S_LM_RD: begin
        lm_ra = (op_q == rcdsa_pkg::OP_DUP3) ? tfd_idx : fd_idx;
      end
      rcdsa_pkg::S_LM_GOT: begin
        if (op_q == rcdsa_pkg::OP_DUP3) begin
          ts_d = lm_rd;
        end else begin
          ks_d = lm_rd;
        end
      end
      rcdsa_pkg::S_LM_GOT2: begin
        ks_d = lm_rd;
        if (!tv && !sv) begin
          res_status_d = rcdsa_pkg::STS_BAD;
        end
      end
      rcdsa_pkg::S_T_RD: begin
        cm_ra = ts_q;
      end
      rcdsa_pkg::S_T_CHK: begin
        tcnt_d = cm_rd;
        priority if (cnt_zero) begin
          res_status_d = rcdsa_pkg::STS_COUNT;
        end else if (!sv) begin
          cm_we        = 1'b1;
          cm_wa        = ts_q;
          cm_wd        = cnt_dec;
          lv_clr       = 1'b1;
          res_freed_d  = cnt_one;
          res_status_d = rcdsa_pkg::STS_BAD;
        end else if (ts_q == ks_q) begin
          res_value_d = rcdsa_pkg::VALUE_W'(tfd_idx);
        end else begin
          res_status_d = rcdsa_pkg::STS_OK;
        end
      end
      rcdsa_pkg::S_LV_SCAN: begin
        priority if (ffz_res.found) begin
          nf_d = found_fd;
        end else if (w_l_last) begin
          res_status_d = rcdsa_pkg::STS_FULL;
        end else begin
          w_d = w_q + WW'(1);
        end
      end
      rcdsa_pkg::S_CNT_CHK: begin
        unique case (op_q)
          rcdsa_pkg::OP_RELEASE, rcdsa_pkg::OP_CLOSE: begin
            if (cnt_zero) begin
              res_status_d = rcdsa_pkg::STS_COUNT;
            end else begin
              cm_we       = 1'b1;
              cm_wd       = cnt_dec;
              res_freed_d = cnt_one;
              lv_clr      = (op_q == rcdsa_pkg::OP_CLOSE);
              lv_idx      = fd_idx;
            end
          end
          rcdsa_pkg::OP_ADD_REF, rcdsa_pkg::OP_DUP, rcdsa_pkg::OP_DUP3: begin
            priority if (cnt_zero) begin
              res_status_d = rcdsa_pkg::STS_BAD;
            end else if (cnt_max) begin
              res_status_d = rcdsa_pkg::STS_COUNT;
            end else begin
              cm_we = 1'b1;
              if (op_q == rcdsa_pkg::OP_DUP) begin
                lm_we       = 1'b1;
                lm_wa       = nf_q;
                lv_set      = 1'b1;
                lv_idx      = nf_q;
                res_value_d = rcdsa_pkg::VALUE_W'(nf_q);
              end else if (op_q == rcdsa_pkg::OP_DUP3) begin
                lm_we       = 1'b1;
                lv_set      = 1'b1;
                res_value_d = rcdsa_pkg::VALUE_W'(tfd_idx);
              end
            end
          end
          default: ;
        endcase
      end
      rcdsa_pkg::S_T_WR: begin
        cm_we       = 1'b1;
        cm_wa       = ts_q;
        cm_wd       = tcnt_q - COUNT_BITS'(1);
        res_freed_d = tcnt_one;
      end
      rcdsa_pkg::S_FB_RD: begin
        bm_ra = fb_waddr;
      end
      rcdsa_pkg::S_FB_WR: begin
        bm_we = 1'b1;
        bm_wa = fb_waddr;
        bm_wd = bm_rd & ~(WORD_W'(1) << fb_bit);
      end
      rcdsa_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_value_d  = res_value_q;
          out_freed_d  = res_freed_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rcdsa_pkg::S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      lvalid_q    <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (lv_set) begin
        lvalid_q[lv_idx] <= 1'b1;
      end else if (lv_clr) begin
        lvalid_q[lv_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      slot_q <= slot_i;
      fd_q   <= local_fd_i;
      tfd_q  <= target_fd_i;
    end
    ks_q         <= ks_d;
    ts_q         <= ts_d;
    nf_q         <= nf_d;
    w_q          <= w_d;
    tcnt_q       <= tcnt_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_freed_q  <= res_freed_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_freed_q  <= out_freed_d;
  end

  assign in_stall_o   = (state_q != rcdsa_pkg::S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign value_o      = out_value_q;
  assign slot_freed_o = out_freed_q;

  // No transaction is taken while the count memory is being cleared.
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rcdsa_pkg::S_CLEAR |-> in_stall_o)
    else $error("input accepted during the clearing pass");

  // The second count write of dup3 only follows a successful increment of the source slot.
  a_target_write_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rcdsa_pkg::S_T_WR |->
      $past(state_q) == rcdsa_pkg::S_CNT_CHK && op_q == rcdsa_pkg::OP_DUP3)
    else $error("target count written out of sequence");

  // A bitmap bit is cleared only for a slot whose count just reached zero.
  a_free_has_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rcdsa_pkg::S_FB_WR |-> res_freed_q)
    else $error("bitmap cleared without a freed slot");

  // A result is loaded only when the output register is free.
  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_value_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the reference-counted descriptor slot allocator.
`timescale 1ns / 1ps

module tb;
  import rcdsa_pkg::*;

  localparam int GLOBAL_SLOTS = GLOBAL_SLOTS_DEF;
  localparam int LOCAL_SLOTS  = LOCAL_SLOTS_DEF;
  localparam int COUNT_BITS   = COUNT_BITS_DEF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    status_e              status;
    logic [VALUE_W-1:0]   value;
    logic                 freed;
  } table_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       operation_i = '0;
  logic [SLOT_IN_W-1:0]  slot_i = '0;
  logic [FD_W-1:0]       local_fd_i = '0;
  logic [FD_W-1:0]       target_fd_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [VALUE_W-1:0]    value_o;
  logic                  slot_freed_o;

  refcounted_descriptor_slot_allocator u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .slot_i       (slot_i),
    .local_fd_i   (local_fd_i),
    .target_fd_i  (target_fd_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .value_o      (value_o),
    .slot_freed_o (slot_freed_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic                  slot_busy [GLOBAL_SLOTS];
  logic [COUNT_BITS-1:0] use_count [GLOBAL_SLOTS];
  logic                  fd_live   [LOCAL_SLOTS];
  logic [SLOT_IN_W-1:0]  fd_map    [LOCAL_SLOTS];

  table_result_t expected_results [$];
  table_result_t last_expected;
  int unsigned   requests_sent = 0;
  int unsigned   results_checked = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  logic          offering = 1'b0;

  int unsigned   hold_len = 0;
  int unsigned   hold_left = 0;
  logic          hold_kick = 1'b0;
  logic          hold_seen = 1'b0;

  function automatic void clear_table_model();
    for (int i = 0; i < GLOBAL_SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      use_count[i] = '0;
    end
    for (int i = 0; i < LOCAL_SLOTS; i++) begin
      fd_live[i] = 1'b0;
      fd_map[i]  = '0;
    end
  endfunction

  function automatic logic decrement_count(logic [SLOT_IN_W-1:0] s);
    use_count[s] = use_count[s] - 1'b1;
    if (use_count[s] == '0) begin
      slot_busy[s] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic table_result_t predict_table_op(logic [OP_W-1:0] op,
                                                     logic [SLOT_IN_W-1:0] s,
                                                     logic [FD_W-1:0] fd,
                                                     logic [FD_W-1:0] tfd);
    table_result_t        r;
    logic                 hit;
    logic                 tv;
    logic                 sv;
    logic [SLOT_IN_W-1:0] ts;
    logic [SLOT_IN_W-1:0] ss;
    int                   nf;
    r = '{STS_OK, '0, 1'b0};
    case (op)
      OP_ALLOC: begin
        r.status = STS_FULL;
        hit = 1'b0;
        for (int i = 0; i < GLOBAL_SLOTS; i++) begin
          if (!hit && !slot_busy[i]) begin
            hit = 1'b1;
            slot_busy[i] = 1'b1;
            use_count[i] = 1;
            r.status = STS_OK;
            r.value = VALUE_W'(i);
          end
        end
      end
      OP_ADD_REF: begin
        if (int'(s) >= GLOBAL_SLOTS || !slot_busy[s]) r.status = STS_BAD;
        else if (use_count[s] == COUNT_MAX) r.status = STS_COUNT;
        else use_count[s] = use_count[s] + 1'b1;
      end
      OP_RELEASE: begin
        if (int'(s) >= GLOBAL_SLOTS) r.status = STS_BAD;
        else if (use_count[s] == '0) r.status = STS_COUNT;
        else r.freed = decrement_count(s);
      end
      OP_CLOSE: begin
        if (int'(fd) >= LOCAL_SLOTS || !fd_live[fd]) begin
          r.status = STS_BAD;
        end else if (use_count[fd_map[fd]] == '0) begin
          r.status = STS_COUNT;
        end else begin
          r.freed = decrement_count(fd_map[fd]);
          fd_live[fd] = 1'b0;
          fd_map[fd] = '0;
        end
      end
      OP_DUP: begin
        if (int'(fd) >= LOCAL_SLOTS || !fd_live[fd]) begin
          r.status = STS_BAD;
        end else begin
          ss = fd_map[fd];
          nf = LOCAL_SLOTS;
          for (int i = LOCAL_SLOTS - 1; i >= 0; i--) begin
            if (!fd_live[i]) nf = i;
          end
          if (nf >= LOCAL_SLOTS) r.status = STS_FULL;
          else if (!slot_busy[ss]) r.status = STS_BAD;
          else if (use_count[ss] == COUNT_MAX) r.status = STS_COUNT;
          else begin
            use_count[ss] = use_count[ss] + 1'b1;
            fd_live[nf] = 1'b1;
            fd_map[nf] = ss;
            r.value = VALUE_W'(nf);
          end
        end
      end
      OP_DUP3: begin
        if (int'(fd) >= LOCAL_SLOTS || int'(tfd) >= LOCAL_SLOTS) begin
          r.status = STS_BAD;
        end else begin
          tv = fd_live[tfd];
          sv = fd_live[fd];
          ts = fd_map[tfd];
          ss = fd_map[fd];
          if (tv && use_count[ts] == '0) begin
            r.status = STS_COUNT;
          end else if (!sv) begin
            if (tv) r.freed = decrement_count(ts);
            fd_live[tfd] = 1'b0;
            fd_map[tfd] = '0;
            r.status = STS_BAD;
          end else if (tv && ts == ss) begin
            r.value = VALUE_W'(tfd);
          end else if (!slot_busy[ss]) begin
            r.status = STS_BAD;
          end else if (use_count[ss] == COUNT_MAX) begin
            r.status = STS_COUNT;
          end else begin
            if (tv) r.freed = decrement_count(ts);
            use_count[ss] = use_count[ss] + 1'b1;
            fd_live[tfd] = 1'b1;
            fd_map[tfd] = ss;
            r.value = VALUE_W'(tfd);
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_IN_W-1:0] pick_live_slot(logic [SLOT_IN_W-1:0] start);
    logic [SLOT_IN_W-1:0] s;
    logic [SLOT_IN_W-1:0] found;
    logic                 hit;
    s = start;
    found = start;
    hit = 1'b0;
    for (int k = 0; k < GLOBAL_SLOTS; k++) begin
      if (!hit && slot_busy[s]) begin
        found = s;
        hit = 1'b1;
      end
      s = s + 1'b1;
    end
    return found;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_IN_W-1:0] s,
                              input logic [FD_W-1:0] fd, input logic [FD_W-1:0] tfd);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0 && offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    repeat (gap) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    slot_i      <= s;
    local_fd_i  <= fd;
    target_fd_i <= tfd;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    last_expected = predict_table_op(op, s, fd, tfd);
    expected_results.push_back(last_expected);
    requests_sent++;
  endtask

  task automatic wait_for_results();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idle(int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  task automatic test_directed();
    send_request(OP_ALLOC, '1, '1, '1);
    send_request(OP_ALLOC, '0, '0, '0);
    send_request(OP_ADD_REF, 10'd0, 8'd0, 8'd0);
    send_request(OP_RELEASE, 10'd0, 8'd0, 8'd0);
    send_request(OP_RELEASE, 10'd0, 8'd0, 8'd0);
    send_request(OP_RELEASE, 10'd0, 8'd0, 8'd0);
    send_request(OP_ADD_REF, 10'd0, 8'd0, 8'd0);
    send_request(OP_ADD_REF, '1, '1, '1);
    send_request(OP_RELEASE, '1, '1, '1);
    send_request(OP_CLOSE, '0, 8'd0, '0);
    send_request(OP_CLOSE, '1, '1, '1);
    send_request(OP_DUP, '0, 8'd0, '0);
    send_request(OP_DUP, '1, '1, '1);
    send_request(OP_DUP3, '0, 8'd0, '1);
    send_request(OP_DUP3, '1, '1, 8'd0);
    send_request(OP_DUP3, '0, 8'd7, 8'd7);
    send_request(OP_UNUSED_6, '1, '1, '1);
    send_request(OP_UNUSED_7, '1, '1, '1);
    send_request(OP_ALLOC, '0, '0, '0);
    send_request(OP_RELEASE, 10'd1, 8'd0, 8'd0);
    send_request(OP_RELEASE, 10'd0, 8'd0, 8'd0);
  endtask

  // The receiver holds off long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    hold_len = 400;
    hold_kick <= ~hold_kick;
    for (int k = 0; k < 24; k++) begin
      if (k % 3 == 2) send_request(OP_RELEASE, pick_live_slot($urandom), $urandom, $urandom);
      else send_request(OP_ALLOC, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_slot_exhaustion();
    int live;
    live = 0;
    for (int i = 0; i < GLOBAL_SLOTS; i++) if (slot_busy[i]) live++;
    repeat (GLOBAL_SLOTS - live) send_request(OP_ALLOC, $urandom, $urandom, $urandom);
    send_request(OP_ALLOC, $urandom, $urandom, $urandom);
    send_request(OP_RELEASE, '1, $urandom, $urandom);
    send_request(OP_ALLOC, $urandom, $urandom, $urandom);
    for (int i = 0; i < GLOBAL_SLOTS; i++) begin
      while (use_count[i] != '0)
        send_request(OP_RELEASE, SLOT_IN_W'(i), $urandom, $urandom);
    end
  endtask

  task automatic test_count_saturation();
    logic [SLOT_IN_W-1:0] s;
    send_request(OP_ALLOC, $urandom, $urandom, $urandom);
    s = last_expected.value;
    while (use_count[s] != COUNT_MAX) send_request(OP_ADD_REF, s, $urandom, $urandom);
    send_request(OP_ADD_REF, s, $urandom, $urandom);
    send_request(OP_RELEASE, s, $urandom, $urandom);
    send_request(OP_ADD_REF, s, $urandom, $urandom);
    send_request(OP_ADD_REF, s, $urandom, $urandom);
  endtask

  task automatic test_random_ops(int unsigned n);
    logic [OP_W-1:0]      op;
    logic [SLOT_IN_W-1:0] s;
    int unsigned          pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      s = $urandom;
      if (pick < 30) op = OP_ALLOC;
      else if (pick < 50) op = OP_ADD_REF;
      else if (pick < 75) op = OP_RELEASE;
      else if (pick < 82) op = OP_CLOSE;
      else if (pick < 89) op = OP_DUP;
      else if (pick < 96) op = OP_DUP3;
      else if (pick < 98) op = OP_UNUSED_6;
      else op = OP_UNUSED_7;
      if ((op == OP_ADD_REF || op == OP_RELEASE) && $urandom_range(9) < 8)
        s = pick_live_slot(s);
      send_request(op, s, $urandom, $urandom);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= hold_len;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : result_check
    table_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (value_o !== want.value)
          report_mismatch($sformatf("value got %0d want %0d", value_o, want.value));
        if (slot_freed_o !== want.freed)
          report_mismatch($sformatf("slot_freed got %0b want %0b", slot_freed_o, want.freed));
      end
    end
    if (hold_left != 0) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    clear_table_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_idle(8, 84);
    test_directed();
    wait_for_results();

    set_idle(0, 0);
    test_backpressure();
    wait_for_results();

    test_slot_exhaustion();
    wait_for_results();
    test_count_saturation();
    wait_for_results();

    set_idle(8, 84);
    test_random_ops(170);
    wait_for_results();
    set_idle(84, 8);
    test_random_ops(170);
    wait_for_results();
    set_idle(0, 0);
    test_random_ops(170);
    wait_for_results();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered alloc to a full table, count saturation and underflow, invalid handles,");
    $display("%0d requests sent, %0d results checked, %0d mismatches", requests_sent,
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rcdsa_pkg.sv
hw/rtl/rcdsa_ram.sv
hw/rtl/rcdsa_ffz.sv
hw/rtl/refcounted_descriptor_slot_allocator.sv
dv/tb.sv
